/* rtl/floor_plane_projection_defines.svh */
// Assertion macros shared by the floor plane projection RTL.
`ifndef FLOOR_PLANE_PROJECTION_DEFINES_SVH
`define FLOOR_PLANE_PROJECTION_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define FPP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpp assertion failed");

// Consequent holds in the cycle after the antecedent.
`define FPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpp assertion failed");

`endif

/* rtl/fpp_pkg.sv */
// Package with shared types, codes and constants of the floor plane projection unit.
package fpp_pkg;

   localparam int SCREEN_WIDTH_DEF  = 396;
   localparam int SCREEN_HEIGHT_DEF = 224;
   localparam int DEPTH_BITS_DEF    = 16;

   localparam int ROT_SHIFT   = 15;
   localparam int SCALE_SHIFT = 6;
   localparam int OUT_SHIFT   = 2;

   localparam int ACT_W     = 2;
   localparam int PIX_X_W   = 9;
   localparam int PIX_Y_W   = 8;
   localparam int PT_W      = 21;
   localparam int IDX_W     = 8;
   localparam int ENT_W     = 16;
   localparam int TRIG_W    = 17;
   localparam int HOR_W     = 8;
   localparam int OFF_W     = 24;
   localparam int WORLD_W   = 24;
   localparam int SX_W      = 16;
   localparam int SY_W      = 9;
   localparam int DEP_W     = 24;
   localparam int STS_W     = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 24;
   localparam int Q_W       = 26;
   localparam int CX_W      = 10;
   localparam int MB_W      = 18;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COS      = 3'd0,
      CSR_SIN      = 3'd1,
      CSR_HORIZON  = 3'd2,
      CSR_OFFSET_X = 3'd3,
      CSR_OFFSET_Y = 3'd4
   } fpp_csr_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_LOAD = 2'd0,
      ACT_S2W  = 2'd1,
      ACT_W2S  = 2'd2,
      ACT_NOP  = 2'd3
   } fpp_action_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK   = 2'd0,
      STS_ROW  = 2'd1,
      STS_NEAR = 2'd2
   } fpp_status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_ROW,
      S_SM0, S_SM1, S_SM2, S_SM3, S_SM4, S_SM5,
      S_WM0, S_WM1, S_WM2, S_WM3, S_WM4,
      S_SCAN, S_NUM, S_DIV, S_FIN
   } fpp_state_type;

   typedef enum logic [4:0] {
      STEP_NONE, STEP_ROW,
      STEP_SM0, STEP_SM1, STEP_SM2, STEP_SM3, STEP_SM4, STEP_SM5,
      STEP_WM0, STEP_WM1, STEP_WM2, STEP_WM3, STEP_WM4,
      STEP_SCAN, STEP_NUM, STEP_DIV
   } fpp_step_type;

   typedef struct packed {
      logic         capture;
      fpp_step_type step;
      logic         out_load;
   } fpp_cmd_type;

   typedef struct packed {
      fpp_action_type action;
      logic           row_bad;
      logic           scan_done;
      logic           near;
      logic           div_done;
      logic           out_free;
   } fpp_sts_type;

endpackage

/* rtl/fpp_ctrl.sv */
// Sequencer state machine of the floor plane projection unit.
`include "floor_plane_projection_defines.svh"

module fpp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output fpp_pkg::fpp_cmd_type cmd,
   input  fpp_pkg::fpp_sts_type sts
);
   import fpp_pkg::*;

   fpp_state_type state_ff;
   fpp_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            unique case (sts.action)
               ACT_S2W: state_in = S_ROW;
               ACT_W2S: state_in = S_WM0;
               default: state_in = S_FIN;
            endcase
         end
         S_ROW:  state_in = sts.row_bad ? S_FIN : S_SM0;
         S_SM0:  state_in = S_SM1;
         S_SM1:  state_in = S_SM2;
         S_SM2:  state_in = S_SM3;
         S_SM3:  state_in = S_SM4;
         S_SM4:  state_in = S_SM5;
         S_SM5:  state_in = S_FIN;
         S_WM0:  state_in = S_WM1;
         S_WM1:  state_in = S_WM2;
         S_WM2:  state_in = S_WM3;
         S_WM3:  state_in = S_WM4;
         S_WM4:  state_in = S_SCAN;
         S_SCAN: begin
            if (sts.scan_done) state_in = S_NUM;
         end
         S_NUM:  state_in = sts.near ? S_FIN : S_DIV;
         S_DIV: begin
            if (sts.div_done) state_in = S_FIN;
         end
         S_FIN: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = (state_ff != S_IDLE);
      cmd.capture  = (state_ff == S_IDLE) && req_valid;
      cmd.out_load = (state_ff == S_FIN) && sts.out_free;
      unique case (state_ff)
         S_ROW:   cmd.step = STEP_ROW;
         S_SM0:   cmd.step = STEP_SM0;
         S_SM1:   cmd.step = STEP_SM1;
         S_SM2:   cmd.step = STEP_SM2;
         S_SM3:   cmd.step = STEP_SM3;
         S_SM4:   cmd.step = STEP_SM4;
         S_SM5:   cmd.step = STEP_SM5;
         S_WM0:   cmd.step = STEP_WM0;
         S_WM1:   cmd.step = STEP_WM1;
         S_WM2:   cmd.step = STEP_WM2;
         S_WM3:   cmd.step = STEP_WM3;
         S_WM4:   cmd.step = STEP_WM4;
         S_SCAN:  cmd.step = STEP_SCAN;
         S_NUM:   cmd.step = STEP_NUM;
         S_DIV:   cmd.step = STEP_DIV;
         default: cmd.step = STEP_NONE;
      endcase
   end

   `FPP_ASSERT_NEXT(a_capture_dispatch, clock, reset, cmd.capture, state_ff == S_DISPATCH)
   `FPP_ASSERT_NEXT(a_div_ends_fin, clock, reset, (state_ff == S_DIV) && sts.div_done, state_ff == S_FIN)
   `FPP_ASSERT_NEXT(a_fin_holds, clock, reset, (state_ff == S_FIN) && !sts.out_free, state_ff == S_FIN)

endmodule

/* rtl/fpp_dpath.sv */
// Datapath of the floor plane projection unit: registers, table, multiplier, search, divider.
module fpp_dpath #(
   parameter int SCREEN_WIDTH  = fpp_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = fpp_pkg::SCREEN_HEIGHT_DEF,
   parameter int DEPTH_BITS    = fpp_pkg::DEPTH_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  fpp_pkg::fpp_cmd_type                    cmd,
   output fpp_pkg::fpp_sts_type                    sts,
   input  logic [fpp_pkg::ACT_W-1:0]               req_action,
   input  logic [fpp_pkg::PIX_X_W-1:0]             req_pixel_x,
   input  logic [fpp_pkg::PIX_Y_W-1:0]             req_pixel_y,
   input  logic signed [fpp_pkg::PT_W-1:0]         req_point_x,
   input  logic signed [fpp_pkg::PT_W-1:0]         req_point_y,
   input  logic [fpp_pkg::IDX_W-1:0]               req_entry_index,
   input  logic [fpp_pkg::ENT_W-1:0]               req_entry_depth,
   input  logic                                   csr_write_en,
   input  logic [fpp_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [fpp_pkg::CSR_DAT_W-1:0]           csr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [fpp_pkg::WORLD_W-1:0]      rsp_world_x_out,
   output logic signed [fpp_pkg::WORLD_W-1:0]      rsp_world_y_out,
   output logic signed [fpp_pkg::SX_W-1:0]         rsp_screen_x_out,
   output logic [fpp_pkg::SY_W-1:0]                rsp_screen_y_out,
   output logic signed [fpp_pkg::DEP_W-1:0]        rsp_depth_out,
   output logic [fpp_pkg::STS_W-1:0]               rsp_status
);
   import fpp_pkg::*;

   localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
   localparam int LIM_W0 = $clog2(SCREEN_HEIGHT + 1) + 2;
   localparam int LIM_W  = (LIM_W0 > 10) ? LIM_W0 : 10;
   localparam int CNT_W  = LIM_W - 1;
   localparam int DX_W   = DEPTH_BITS + 5;
   localparam int MA_W   = (DX_W > Q_W) ? DX_W : Q_W;
   localparam int P_W    = MA_W + MB_W;
   localparam int ACC_W  = P_W - ROT_SHIFT + 1;
   localparam int SUM_W  = ACC_W + 1;
   localparam int E_W    = ACC_W + 1;
   localparam int NUM_W  = ACC_W + 11;
   localparam int DEN_W  = ACC_W - 1;
   localparam int DIVC_W = $clog2(NUM_W);
   localparam logic signed [NUM_W-1:0] QUARTER_N = NUM_W'(SCREEN_WIDTH / 4);
   localparam logic [CX_W-1:0] QUARTER_C = CX_W'(SCREEN_WIDTH / 4);
   localparam logic signed [ACC_W-1:0] DEP_MAX = ACC_W'(8388607);
   localparam logic signed [ACC_W-1:0] DEP_MIN = -DEP_MAX - ACC_W'(1);
   localparam logic [NUM_W-1:0] SX_POS_LIM = NUM_W'(32767);
   localparam logic [NUM_W-1:0] SX_NEG_LIM = NUM_W'(32768);

   // configuration
   logic signed [TRIG_W-1:0] cos_ff, cos_in, sin_ff, sin_in;
   logic [HOR_W-1:0]         hor_ff, hor_in;
   logic signed [OFF_W-1:0]  offx_ff, offx_in, offy_ff, offy_in;

   // request
   fpp_action_type           act_ff, act_in;
   logic [PIX_X_W-1:0]       px_ff, px_in;
   logic [PIX_Y_W-1:0]       py_ff, py_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [ENT_W-1:0]         ent_ff, ent_in;
   logic signed [Q_W-1:0]    qx_ff, qx_in, qy_ff, qy_in;

   // table
   logic [DEPTH_BITS-1:0]    mem [SCREEN_HEIGHT];
   logic [DEPTH_BITS-1:0]    rd_data_ff;
   logic                     mem_we, mem_re;
   logic [ROW_W-1:0]         mem_waddr, mem_raddr;

   // arithmetic
   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [P_W-1:0]    prod_ff, prod_in;
   logic signed [MA_W-1:0]   sx2_ff, sx2_in;
   logic signed [ACC_W-1:0]  ax_ff, ax_in, ay_ff, ay_in;
   logic signed [ACC_W-1:0]  shr15;

   // search
   logic [CNT_W-1:0]         scan_cnt_ff, scan_cnt_in, cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0]         best_ff, best_in;
   logic                     cmp_vld_ff, cmp_vld_in, found_ff, found_in;
   logic [E_W-1:0]           bestd_ff, bestd_in;

   // divider
   logic [DEN_W-1:0]         rem_ff, rem_in, den_ff, den_in;
   logic [NUM_W-1:0]         quo_ff, quo_in;
   logic                     neg_ff, neg_in;
   logic [DIVC_W-1:0]        divc_ff, divc_in;

   // result
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [WORLD_W-1:0] wx_ff, wx_in, wy_ff, wy_in;
   logic signed [SX_W-1:0]   sx_ff, sx_in;
   logic [SY_W-1:0]          sy_ff, sy_in;
   logic signed [DEP_W-1:0]  dep_ff, dep_in;
   logic [STS_W-1:0]         sts_ff, sts_in;

   // helpers
   logic [PIX_Y_W:0]         row_diff;
   logic [CNT_W-1:0]         row_ext, idx_ext;
   logic                     row_bad, idx_bad, scan_go;
   logic signed [LIM_W-1:0]  lim;
   logic signed [CX_W-1:0]   cx;
   logic signed [DEPTH_BITS:0] d_s;
   logic signed [E_W-1:0]    diff;
   logic [E_W-1:0]           e_mag;
   logic signed [NUM_W-1:0]  num_c;
   logic signed [DEN_W-1:0]  half;
   logic [DEN_W:0]           rem_sh;
   logic                     ge;
   logic signed [SUM_W-1:0]  wx_sum, wy_sum, wx_shr, wy_shr;

   assign row_diff = {1'b0, py_ff} - {1'b0, hor_ff};
   assign row_ext  = CNT_W'(row_diff[PIX_Y_W-1:0]);
   assign idx_ext  = CNT_W'(idx_ff);
   assign row_bad  = row_diff[PIX_Y_W] || ({1'b0, row_ext} >= LIM_W'(SCREEN_HEIGHT));
   assign idx_bad  = {1'b0, idx_ext} >= LIM_W'(SCREEN_HEIGHT);
   assign lim      = $signed(LIM_W'(SCREEN_HEIGHT - 2)) - $signed(LIM_W'(hor_ff));
   assign scan_go  = $signed({1'b0, scan_cnt_ff}) < lim;
   assign cx       = $signed(CX_W'(px_ff[PIX_X_W-1:1])) - $signed(QUARTER_C);
   assign d_s      = $signed({1'b0, rd_data_ff});
   assign shr15    = ACC_W'(prod_ff >>> ROT_SHIFT);
   assign diff     = $signed(E_W'(rd_data_ff)) - E_W'(ay_ff);
   assign e_mag    = diff[E_W-1] ? E_W'(-diff) : E_W'(diff);
   assign num_c    = (NUM_W'(ax_ff) <<< SCALE_SHIFT) + NUM_W'(ay_ff) * QUARTER_N;
   assign half     = ay_ff[ACC_W-1:1];
   assign rem_sh   = {rem_ff, quo_ff[NUM_W-1]};
   assign ge       = rem_sh >= {1'b0, den_ff};
   assign wx_sum   = SUM_W'(ax_ff >>> 1) + SUM_W'(offx_ff);
   assign wy_sum   = SUM_W'(ay_ff >>> 1) + SUM_W'(offy_ff);
   assign wx_shr   = wx_sum >>> OUT_SHIFT;
   assign wy_shr   = wy_sum >>> OUT_SHIFT;

   assign mem_we    = cmd.out_load && (act_ff == ACT_LOAD) && !idx_bad;
   assign mem_waddr = idx_ext[ROW_W-1:0];
   assign mem_re    = ((cmd.step == STEP_ROW) && !row_bad) ||
                      ((cmd.step == STEP_SCAN) && scan_go);
   assign mem_raddr = (cmd.step == STEP_ROW) ? row_ext[ROW_W-1:0] : scan_cnt_ff[ROW_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= DEPTH_BITS'(ent_ff);
      if (mem_re) rd_data_ff <= mem[mem_raddr];
   end

   always_comb begin
      mul_a = sx2_ff;
      mul_b = MB_W'(cos_ff);
      unique case (cmd.step)
         STEP_SM0: begin mul_a = MA_W'(d_s); mul_b = MB_W'(cx);     end
         STEP_SM1: begin mul_a = MA_W'(d_s); mul_b = MB_W'(sin_ff); end
         STEP_SM2: begin mul_a = MA_W'(d_s); mul_b = MB_W'(cos_ff); end
         STEP_SM3: begin mul_a = sx2_ff;     mul_b = MB_W'(cos_ff); end
         STEP_SM4: begin mul_a = sx2_ff;     mul_b = MB_W'(sin_ff); end
         STEP_WM0: begin mul_a = MA_W'(qx_ff); mul_b = MB_W'(cos_ff); end
         STEP_WM1: begin mul_a = MA_W'(qy_ff); mul_b = -MB_W'(sin_ff); end
         STEP_WM2: begin mul_a = MA_W'(qy_ff); mul_b = MB_W'(cos_ff); end
         STEP_WM3: begin mul_a = MA_W'(qx_ff); mul_b = -MB_W'(sin_ff); end
         default: begin mul_a = sx2_ff; mul_b = MB_W'(cos_ff); end
      endcase
   end

   always_comb begin
      cos_in = cos_ff; sin_in = sin_ff; hor_in = hor_ff;
      offx_in = offx_ff; offy_in = offy_ff;
      act_in = act_ff; px_in = px_ff; py_in = py_ff; idx_in = idx_ff; ent_in = ent_ff;
      qx_in = qx_ff; qy_in = qy_ff;
      prod_in = mul_a * mul_b;
      sx2_in = sx2_ff; ax_in = ax_ff; ay_in = ay_ff;
      scan_cnt_in = scan_cnt_ff; cmp_idx_in = cmp_idx_ff; cmp_vld_in = cmp_vld_ff;
      best_in = best_ff; bestd_in = bestd_ff; found_in = found_ff;
      rem_in = rem_ff; den_in = den_ff; quo_in = quo_ff; neg_in = neg_ff; divc_in = divc_ff;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_COS:      cos_in  = TRIG_W'(csr_data);
            CSR_SIN:      sin_in  = TRIG_W'(csr_data);
            CSR_HORIZON:  hor_in  = HOR_W'(csr_data);
            CSR_OFFSET_X: offx_in = OFF_W'(csr_data);
            CSR_OFFSET_Y: offy_in = OFF_W'(csr_data);
            default: ;
         endcase
      end

      if (cmd.capture) begin
         act_in = fpp_action_type'(req_action);
         px_in  = req_pixel_x;
         py_in  = req_pixel_y;
         idx_in = req_entry_index;
         ent_in = req_entry_depth;
         qx_in  = ((Q_W'(req_point_x) <<< 2) - Q_W'(offx_ff)) <<< 1;
         qy_in  = ((Q_W'(req_point_y) <<< 2) - Q_W'(offy_ff)) <<< 1;
         scan_cnt_in = '0;
         cmp_vld_in  = 1'b0;
         found_in    = 1'b0;
         best_in     = '0;
      end

      unique case (cmd.step)
         STEP_SM1: sx2_in = prod_ff[MA_W+SCALE_SHIFT-1:SCALE_SHIFT];
         STEP_SM2: ax_in  = shr15;
         STEP_SM3: ay_in  = shr15;
         STEP_SM4: ax_in  = ax_ff + shr15;
         STEP_SM5: ay_in  = ay_ff - shr15;
         STEP_WM1: ax_in  = shr15;
         STEP_WM2: ax_in  = ax_ff + shr15;
         STEP_WM3: ay_in  = shr15;
         STEP_WM4: ay_in  = ay_ff - shr15;
         STEP_SCAN: begin
            cmp_vld_in = scan_go;
            cmp_idx_in = scan_cnt_ff;
            if (scan_go) scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            if (cmp_vld_ff && (!found_ff || (e_mag < bestd_ff))) begin
               found_in = 1'b1;
               bestd_in = e_mag;
               best_in  = cmp_idx_ff;
            end
         end
         STEP_NUM: begin
            quo_in  = num_c[NUM_W-1] ? NUM_W'(-num_c) : NUM_W'(num_c);
            den_in  = half[DEN_W-1] ? DEN_W'(-half) : DEN_W'(half);
            neg_in  = num_c[NUM_W-1] ^ half[DEN_W-1];
            rem_in  = '0;
            divc_in = '0;
         end
         STEP_DIV: begin
            rem_in  = ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : DEN_W'(rem_sh);
            quo_in  = {quo_ff[NUM_W-2:0], ge};
            divc_in = divc_ff + DIVC_W'(1);
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wx_in = wx_ff; wy_in = wy_ff; sx_in = sx_ff; sy_in = sy_ff;
      dep_in = dep_ff; sts_in = sts_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         wx_in = '0; wy_in = '0; sx_in = '0; sy_in = '0; dep_in = '0;
         sts_in = STS_OK;
         unique case (act_ff)
            ACT_LOAD: begin
               if (idx_bad) sts_in = STS_ROW;
            end
            ACT_S2W: begin
               if (row_bad) begin
                  sts_in = STS_ROW;
               end else begin
                  wx_in = wx_shr[WORLD_W-1:0];
                  wy_in = wy_shr[WORLD_W-1:0];
               end
            end
            ACT_W2S: begin
               sy_in = SY_W'(best_ff) + SY_W'(hor_ff);
               priority if (ay_ff > DEP_MAX) dep_in = DEP_W'(DEP_MAX);
               else if (ay_ff < DEP_MIN)     dep_in = DEP_W'(DEP_MIN);
               else                          dep_in = ay_ff[DEP_W-1:0];
               priority if (half == '0) begin
                  sx_in  = SX_W'(32767);
                  sts_in = STS_NEAR;
               end else begin
                  if (!found_ff) sts_in = STS_ROW;
                  priority if (neg_ff && (quo_ff > SX_NEG_LIM)) sx_in = SX_W'(-32768);
                  else if (neg_ff)                            sx_in = SX_W'(-quo_ff);
                  else if (quo_ff > SX_POS_LIM)               sx_in = SX_W'(32767);
                  else                                        sx_in = SX_W'(quo_ff);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff       <= TRIG_W'(32768);
         sin_ff       <= '0;
         hor_ff       <= '0;
         offx_ff      <= '0;
         offy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         act_ff       <= ACT_NOP;
      end else begin
         cos_ff       <= cos_in;
         sin_ff       <= sin_in;
         hor_ff       <= hor_in;
         offx_ff      <= offx_in;
         offy_ff      <= offy_in;
         rsp_valid_ff <= rsp_valid_in;
         act_ff       <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in; py_ff <= py_in; idx_ff <= idx_in; ent_ff <= ent_in;
      qx_ff <= qx_in; qy_ff <= qy_in;
      prod_ff <= prod_in; sx2_ff <= sx2_in; ax_ff <= ax_in; ay_ff <= ay_in;
      scan_cnt_ff <= scan_cnt_in; cmp_idx_ff <= cmp_idx_in; cmp_vld_ff <= cmp_vld_in;
      best_ff <= best_in; bestd_ff <= bestd_in; found_ff <= found_in;
      rem_ff <= rem_in; den_ff <= den_in; quo_ff <= quo_in; neg_ff <= neg_in;
      divc_ff <= divc_in;
      wx_ff <= wx_in; wy_ff <= wy_in; sx_ff <= sx_in; sy_ff <= sy_in;
      dep_ff <= dep_in; sts_ff <= sts_in;
   end

   assign sts.action    = act_ff;
   assign sts.row_bad   = row_bad;
   assign sts.scan_done = !scan_go && !cmp_vld_ff;
   assign sts.near      = (half == '0);
   assign sts.div_done  = (divc_ff == DIVC_W'(NUM_W - 1));
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_world_x_out  = wx_ff;
   assign rsp_world_y_out  = wy_ff;
   assign rsp_screen_x_out = sx_ff;
   assign rsp_screen_y_out = sy_ff;
   assign rsp_depth_out    = dep_ff;
   assign rsp_status       = sts_ff;

endmodule

/* rtl/floor_plane_projection.sv */
// A load or the unused action code goes from dispatch straight to the result. Screen to
// world reads the table row and runs the multiplier steps (a row outside the table skips
// them); world to screen runs the multiplier steps, the table scan at one entry per cycle
// and the divider. A too-near depth skips the divider. One request at a time: the next is
// taken in the cycle after the result is loaded, which waits while the output is stalled.
// Synchronous reset clears control and configuration (cos to 32768); depth table not cleared.
module floor_plane_projection #(
   parameter int SCREEN_WIDTH  = fpp_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = fpp_pkg::SCREEN_HEIGHT_DEF,
   parameter int DEPTH_BITS    = fpp_pkg::DEPTH_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [fpp_pkg::ACT_W-1:0]               req_action,
   input  logic [fpp_pkg::PIX_X_W-1:0]             req_pixel_x,
   input  logic [fpp_pkg::PIX_Y_W-1:0]             req_pixel_y,
   input  logic signed [fpp_pkg::PT_W-1:0]         req_point_x,
   input  logic signed [fpp_pkg::PT_W-1:0]         req_point_y,
   input  logic [fpp_pkg::IDX_W-1:0]               req_entry_index,
   input  logic [fpp_pkg::ENT_W-1:0]               req_entry_depth,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [fpp_pkg::WORLD_W-1:0]      rsp_world_x_out,
   output logic signed [fpp_pkg::WORLD_W-1:0]      rsp_world_y_out,
   output logic signed [fpp_pkg::SX_W-1:0]         rsp_screen_x_out,
   output logic [fpp_pkg::SY_W-1:0]                rsp_screen_y_out,
   output logic signed [fpp_pkg::DEP_W-1:0]        rsp_depth_out,
   output logic [fpp_pkg::STS_W-1:0]               rsp_status,
   input  logic                                   csr_write_en,
   input  logic [fpp_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [fpp_pkg::CSR_DAT_W-1:0]           csr_data
);
   import fpp_pkg::*;

   fpp_cmd_type cmd;
   fpp_sts_type sts;

   fpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   fpp_dpath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .DEPTH_BITS    (DEPTH_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_action       (req_action),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_entry_index  (req_entry_index),
      .req_entry_depth  (req_entry_depth),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_world_x_out  (rsp_world_x_out),
      .rsp_world_y_out  (rsp_world_y_out),
      .rsp_screen_x_out (rsp_screen_x_out),
      .rsp_screen_y_out (rsp_screen_y_out),
      .rsp_depth_out    (rsp_depth_out),
      .rsp_status       (rsp_status)
   );

endmodule
